[rtl/psc_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the pressure sensor compensation block.
// Depends on nothing; every other file imports it.
package psc_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int RAW_W      = 24;
	localparam int TEMP_W     = 19;
	localparam int PRES_W     = 32;

	localparam logic [CFG_IDX_W-1:0] REG_VARIANT     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_SENS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PRESS_OFF   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SENS_TCO    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_OFF_TCO     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_REF_TEMP    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_TEMP_COEFF  = 3'd6;

	typedef enum logic [1:0] {
		MODE_30BAR = 2'd0,
		MODE_14BAR = 2'd1,
		MODE_2BAR  = 2'd2
	} variant_t;

	typedef struct packed {
		variant_t                variant;
		logic [CFG_DATA_W-1:0]   pressure_sensitivity;
		logic [CFG_DATA_W-1:0]   pressure_offset;
		logic [CFG_DATA_W-1:0]   sensitivity_temp_coeff;
		logic [CFG_DATA_W-1:0]   offset_temp_coeff;
		logic [CFG_DATA_W-1:0]   reference_temperature;
		logic [CFG_DATA_W-1:0]   temperature_coeff;
	} cfg_t;

endpackage

[rtl/psc_if.sv]
`timescale 1ns / 1ps
// Valid/ready channel interfaces for raw samples and compensated results.
// Depends on psc_pkg for the field widths.
interface psc_sample_if;
	import psc_pkg::*;

	logic             valid;
	logic             ready;
	logic [RAW_W-1:0] raw_pressure;
	logic [RAW_W-1:0] raw_temperature;

	modport source (output valid, raw_pressure, raw_temperature, input ready);
	modport sink (input valid, raw_pressure, raw_temperature, output ready);
endinterface

interface psc_result_if;
	import psc_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [TEMP_W-1:0] temperature_centideg;
	logic signed [PRES_W-1:0] pressure_count;

	modport source (output valid, temperature_centideg, pressure_count, input ready);
	modport sink (input valid, temperature_centideg, pressure_count, output ready);
endinterface

[rtl/psc_cfg_regs.sv]
`timescale 1ns / 1ps
// Calibration and variant register file written through the plain write port.
// Depends on psc_pkg for the register indexes and the cfg_t record.
module psc_cfg_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           we,
	input  logic [psc_pkg::CFG_IDX_W-1:0]  idx,
	input  logic [psc_pkg::CFG_DATA_W-1:0] wdata,
	output psc_pkg::cfg_t                  cfg
);
	import psc_pkg::*;

	cfg_t cfg_q;

	// The unused variant code is stored as the 30 bar variant.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (we) begin
			case (idx)
				REG_VARIANT: begin
					case (wdata[1:0])
						MODE_14BAR: cfg_q.variant <= MODE_14BAR;
						MODE_2BAR:  cfg_q.variant <= MODE_2BAR;
						default:    cfg_q.variant <= MODE_30BAR;
					endcase
				end
				REG_PRESS_SENS: cfg_q.pressure_sensitivity <= wdata;
				REG_PRESS_OFF:  cfg_q.pressure_offset <= wdata;
				REG_SENS_TCO:   cfg_q.sensitivity_temp_coeff <= wdata;
				REG_OFF_TCO:    cfg_q.offset_temp_coeff <= wdata;
				REG_REF_TEMP:   cfg_q.reference_temperature <= wdata;
				REG_TEMP_COEFF: cfg_q.temperature_coeff <= wdata;
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

[rtl/pressure_sensor_compensation_top.sv]
`timescale 1ns / 1ps
// Second-order pressure and temperature compensation, ten-stage pipeline.
// Depends on psc_pkg, psc_if (channel interfaces) and psc_cfg_regs.
//
//   Port       Direction  Carries
//   sample     sink       raw_pressure, raw_temperature (24 bits each)
//   result     source     temperature_centideg (19 bits), pressure_count (32 bits)
//   cfg_*      write      variant and six calibration words, index 0 to 6
//
// One item is accepted per cycle while no stall holds the first stage.
// Reset clears the valid bits and the calibration registers; the data registers are not reset.
// A stalled result holds the last stage and every full stage directly behind it; empty stages
// ahead of them still fill, so new items are taken until every stage is occupied.
module pressure_sensor_compensation_top (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [psc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [psc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	psc_sample_if.sink                     sample,
	psc_result_if.source                   result
);
	import psc_pkg::*;

	localparam int STAGES = 10;
	localparam logic signed [19:0] TEMP_HI = 20'sd262143;
	localparam logic signed [19:0] TEMP_LO = -20'sd262144;
	localparam logic signed [43:0] PRES_HI = 44'sd2147483647;
	localparam logic signed [43:0] PRES_LO = -44'sd2147483648;

	cfg_t cfg;

	psc_cfg_regs u_cfg (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (cfg_we),
		.idx   (cfg_idx),
		.wdata (cfg_wdata),
		.cfg   (cfg)
	);

	logic [STAGES-1:0] stage_vld_q;
	logic [STAGES-1:0] stage_en;

	always_comb begin
		stage_en[STAGES-1] = !stage_vld_q[STAGES-1] || result.ready;
		for (int i = STAGES - 2; i >= 0; i--) begin
			stage_en[i] = !stage_vld_q[i] || stage_en[i+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (stage_en[0]) begin
				stage_vld_q[0] <= sample.valid;
			end
			for (int i = 1; i < STAGES; i++) begin
				if (stage_en[i]) begin
					stage_vld_q[i] <= stage_vld_q[i-1];
				end
			end
		end
	end

	assign sample.ready = stage_en[0];
	assign result.valid = stage_vld_q[STAGES-1];

	// Stage 1: temperature difference from the reference reading.
	logic signed [24:0] dt_s1;
	logic [RAW_W-1:0]   d1_s1;
	variant_t           mode_s1;

	always_ff @(posedge clk) begin
		if (stage_en[0]) begin
			dt_s1   <= $signed({1'b0, sample.raw_temperature})
				- $signed({1'b0, cfg.reference_temperature, 8'd0});
			d1_s1   <= sample.raw_pressure;
			mode_s1 <= cfg.variant;
		end
	end

	// Stage 2: the four products of dt.
	logic signed [41:0] p6_s2;
	logic signed [41:0] p4_s2;
	logic signed [41:0] p3_s2;
	logic [47:0]        dsq_s2;
	logic [RAW_W-1:0]   d1_s2;
	variant_t           mode_s2;
	logic signed [49:0] dsq_full;

	assign dsq_full = dt_s1 * dt_s1;

	always_ff @(posedge clk) begin
		if (stage_en[1]) begin
			p6_s2   <= dt_s1 * $signed({1'b0, cfg.temperature_coeff});
			p4_s2   <= dt_s1 * $signed({1'b0, cfg.offset_temp_coeff});
			p3_s2   <= dt_s1 * $signed({1'b0, cfg.sensitivity_temp_coeff});
			dsq_s2  <= dsq_full[47:0];
			d1_s2   <= d1_s1;
			mode_s2 <= mode_s1;
		end
	end

	// Stage 3: first-order offset and sensitivity, temperature correction term.
	logic signed [17:0] dd_c;
	logic signed [35:0] off1_c;
	logic signed [35:0] sens1_c;
	logic [51:0]        dsq11;
	logic [50:0]        dsq7;
	logic [14:0]        dsq_hi;
	logic [16:0]        t2_c;

	assign dd_c   = p6_s2[40:23];
	assign dsq11  = {4'b0000, dsq_s2} + {3'b000, dsq_s2, 1'b0} + {1'b0, dsq_s2, 3'b000};
	assign dsq7   = {dsq_s2, 3'b000} - {3'b000, dsq_s2};
	assign dsq_hi = dsq_s2[47:33];

	always_comb begin
		if (mode_s2 == MODE_2BAR) begin
			off1_c  = $signed({3'b000, cfg.pressure_offset, 17'd0}) + 36'(p4_s2 >>> 6);
			sens1_c = $signed({4'b0000, cfg.pressure_sensitivity, 16'd0}) + 36'(p3_s2 >>> 7);
		end else begin
			off1_c  = $signed({4'b0000, cfg.pressure_offset, 16'd0}) + 36'(p4_s2 >>> 7);
			sens1_c = $signed({5'b00000, cfg.pressure_sensitivity, 15'd0}) + 36'(p3_s2 >>> 8);
		end
	end

	always_comb begin
		if (p6_s2[41]) begin
			if (mode_s2 == MODE_2BAR) begin
				t2_c = dsq11[51:35];
			end else begin
				t2_c = {2'b00, dsq_hi} + {1'b0, dsq_hi, 1'b0};
			end
		end else begin
			case (mode_s2)
				MODE_2BAR:  t2_c = '0;
				MODE_14BAR: t2_c = {3'b000, dsq7[50:37]};
				default:    t2_c = {5'b00000, dsq_s2[47:37], 1'b0};
			endcase
		end
	end

	logic signed [17:0] dd_s3;
	logic               cold_s3;
	logic               vcold_s3;
	logic signed [35:0] off1_s3;
	logic signed [35:0] sens1_s3;
	logic [16:0]        t2_s3;
	logic [RAW_W-1:0]   d1_s3;
	variant_t           mode_s3;

	always_ff @(posedge clk) begin
		if (stage_en[2]) begin
			dd_s3    <= dd_c;
			cold_s3  <= p6_s2[41];
			vcold_s3 <= dd_c < -18'sd3500;
			off1_s3  <= off1_c;
			sens1_s3 <= sens1_c;
			t2_s3    <= t2_c;
			d1_s3    <= d1_s2;
			mode_s3  <= mode_s2;
		end
	end

	// Stage 4: squares of the temperature deviations, corrected temperature.
	logic signed [18:0] low_c;
	logic signed [35:0] sq_full;
	logic signed [37:0] lsq_full;
	logic signed [19:0] temp2_c;

	assign low_c    = 19'(dd_s3) + 19'sd3500;
	assign sq_full  = dd_s3 * dd_s3;
	assign lsq_full = low_c * low_c;
	assign temp2_c  = 20'(dd_s3) + 20'sd2000 - $signed({3'b000, t2_s3});

	logic [34:0]        sq_s4;
	logic [34:0]        lsq_s4;
	logic signed [19:0] temp2_s4;
	logic               cold_s4;
	logic               vcold_s4;
	logic signed [35:0] off1_s4;
	logic signed [35:0] sens1_s4;
	logic [RAW_W-1:0]   d1_s4;
	variant_t           mode_s4;

	always_ff @(posedge clk) begin
		if (stage_en[3]) begin
			sq_s4    <= sq_full[34:0];
			lsq_s4   <= lsq_full[34:0];
			temp2_s4 <= temp2_c;
			cold_s4  <= cold_s3;
			vcold_s4 <= vcold_s3;
			off1_s4  <= off1_s3;
			sens1_s4 <= sens1_s3;
			d1_s4    <= d1_s3;
			mode_s4  <= mode_s3;
		end
	end

	// Stage 5: second-order offset and sensitivity terms, temperature limit.
	logic [39:0]        sq31;
	logic [40:0]        sq63;
	logic [35:0]        sq3;
	logic [36:0]        sq5;
	logic [37:0]        lsq7;
	logic [38:0]        off2_c;
	logic [38:0]        sens2_c;
	logic signed [18:0] temp_c;

	assign sq31 = {sq_s4, 5'd0} - {5'd0, sq_s4};
	assign sq63 = {sq_s4, 6'd0} - {6'd0, sq_s4};
	assign sq3  = {sq_s4, 1'b0} + {1'b0, sq_s4};
	assign sq5  = {sq_s4, 2'd0} + {2'd0, sq_s4};
	assign lsq7 = {lsq_s4, 3'd0} - {3'd0, lsq_s4};

	always_comb begin
		off2_c  = '0;
		sens2_c = '0;
		if (cold_s4) begin
			if (mode_s4 == MODE_2BAR) begin
				off2_c  = 39'(sq31[39:3]);
				sens2_c = 39'(sq63[40:5]);
			end else begin
				off2_c  = 39'(sq3[35:1]);
				sens2_c = 39'(sq5[36:3]);
				if (vcold_s4) begin
					off2_c  = off2_c + 39'(lsq7);
					sens2_c = sens2_c + 39'({lsq_s4, 2'd0});
				end
			end
		end else if (mode_s4 != MODE_2BAR) begin
			off2_c = 39'(sq_s4[34:4]);
		end
	end

	always_comb begin
		if (temp2_s4 > TEMP_HI) begin
			temp_c = TEMP_HI[18:0];
		end else if (temp2_s4 < TEMP_LO) begin
			temp_c = TEMP_LO[18:0];
		end else begin
			temp_c = temp2_s4[18:0];
		end
	end

	logic [38:0]        off2_s5;
	logic [38:0]        sens2_s5;
	logic signed [18:0] temp_s5;
	logic signed [35:0] off1_s5;
	logic signed [35:0] sens1_s5;
	logic [RAW_W-1:0]   d1_s5;
	variant_t           mode_s5;

	always_ff @(posedge clk) begin
		if (stage_en[4]) begin
			off2_s5  <= off2_c;
			sens2_s5 <= sens2_c;
			temp_s5  <= temp_c;
			off1_s5  <= off1_s4;
			sens1_s5 <= sens1_s4;
			d1_s5    <= d1_s4;
			mode_s5  <= mode_s4;
		end
	end

	// Stage 6: final offset and sensitivity.
	logic signed [39:0] off_s6;
	logic signed [39:0] sens_s6;
	logic signed [18:0] temp_s6;
	logic [RAW_W-1:0]   d1_s6;
	variant_t           mode_s6;

	always_ff @(posedge clk) begin
		if (stage_en[5]) begin
			off_s6  <= 40'(off1_s5) - $signed({1'b0, off2_s5});
			sens_s6 <= 40'(sens1_s5) - $signed({1'b0, sens2_s5});
			temp_s6 <= temp_s5;
			d1_s6   <= d1_s5;
			mode_s6 <= mode_s5;
		end
	end

	// Stage 7: sensitivity times raw pressure, as two partial products.
	logic signed [52:0] pp_hi_s7;
	logic signed [52:0] pp_lo_s7;
	logic signed [39:0] off_s7;
	logic signed [18:0] temp_s7;
	variant_t           mode_s7;

	always_ff @(posedge clk) begin
		if (stage_en[6]) begin
			pp_hi_s7 <= sens_s6 * $signed({1'b0, d1_s6[23:12]});
			pp_lo_s7 <= sens_s6 * $signed({1'b0, d1_s6[11:0]});
			off_s7   <= off_s6;
			temp_s7  <= temp_s6;
			mode_s7  <= mode_s6;
		end
	end

	// Stage 8: partial product sum.
	logic signed [63:0] prod_s8;
	logic signed [39:0] off_s8;
	logic signed [18:0] temp_s8;
	variant_t           mode_s8;

	always_ff @(posedge clk) begin
		if (stage_en[7]) begin
			prod_s8 <= (64'(pp_hi_s7) <<< 12) + 64'(pp_lo_s7);
			off_s8  <= off_s7;
			temp_s8 <= temp_s7;
			mode_s8 <= mode_s7;
		end
	end

	// Stage 9: scaled product minus offset.
	logic signed [43:0] q_s9;
	logic signed [18:0] temp_s9;
	variant_t           mode_s9;

	always_ff @(posedge clk) begin
		if (stage_en[8]) begin
			q_s9    <= 44'(prod_s8 >>> 21) - 44'(off_s8);
			temp_s9 <= temp_s8;
			mode_s9 <= mode_s8;
		end
	end

	// Stage 10: variant scaling and saturation into the result register.
	logic signed [43:0] pscaled_c;
	logic signed [31:0] pres_c;

	always_comb begin
		if (mode_s9 == MODE_30BAR) begin
			pscaled_c = q_s9 >>> 13;
		end else begin
			pscaled_c = q_s9 >>> 15;
		end
		if (pscaled_c > PRES_HI) begin
			pres_c = PRES_HI[31:0];
		end else if (pscaled_c < PRES_LO) begin
			pres_c = PRES_LO[31:0];
		end else begin
			pres_c = pscaled_c[31:0];
		end
	end

	logic signed [TEMP_W-1:0] temp_s10;
	logic signed [PRES_W-1:0] pres_s10;

	always_ff @(posedge clk) begin
		if (stage_en[9]) begin
			temp_s10 <= temp_s9;
			pres_s10 <= pres_c;
		end
	end

	assign result.temperature_centideg = temp_s10;
	assign result.pressure_count       = pres_s10;

endmodule
